FILE: hw/rtl/cpt_pkg.sv
`default_nettype none
package cpt_pkg;
   localparam int MaxDigits = 9;
   localparam int NumW = 30;
   localparam int DivW = 16;
   localparam int CntW = $clog2(NumW + 1);
   localparam int DigW = $clog2(MaxDigits + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_TEST, ST_DIV_WAIT, ST_NEXT_DIV,
      ST_ROT, ST_ROT_WAIT, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic [NumW-1:0] dividend;
      logic [NumW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [NumW-1:0] quot;
      logic [NumW-1:0] rem;
   } div_rsp_type;

   // constant table of powers of ten, selected by k
   function automatic logic [NumW+3:0] pow_ten(input logic [DigW-1:0] k);
      logic [NumW+3:0] p;
      logic [NumW+3:0] pv;
      p = '0;
      pv = (NumW+4)'(1);
      for (int i = 0; i <= MaxDigits; i++) begin
         if (k == DigW'(i)) p = pv;
         pv = (NumW+4)'(pv * 10);
      end
      return p;
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/cpt_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module cpt_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cpt_pkg::div_req_type req,
   output cpt_pkg::div_rsp_type   rsp
);
   logic [cpt_pkg::NumW-1:0] quot_ff, quot_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [cpt_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [cpt_pkg::NumW:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quot_ff[cpt_pkg::NumW-1]} - {1'b0, dsr_ff};
      if (req.start) begin
         quot_in = req.dividend;
         rem_in = '0;
         dsr_in = req.divisor;
         cnt_in = cpt_pkg::CntW'(cpt_pkg::NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, keep the difference when it fits
         if (!trial[cpt_pkg::NumW]) begin
            rem_in = trial[cpt_pkg::NumW-1:0];
            quot_in = {quot_ff[cpt_pkg::NumW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[cpt_pkg::NumW-2:0], quot_ff[cpt_pkg::NumW-1]};
            quot_in = {quot_ff[cpt_pkg::NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == cpt_pkg::CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem = rem_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/cpt_sequencer.sv
`default_nettype none
// Sequencer: digit scan, trial division per rotation, rotation steps.
module cpt_sequencer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [cpt_pkg::NumW-1:0] req_number,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_is_circular_prime,
   output cpt_pkg::div_req_type          dreq,
   input  wire cpt_pkg::div_rsp_type     drsp
);
   localparam int NW = cpt_pkg::NumW;
   localparam int DW = cpt_pkg::DigW;

   cpt_pkg::state_type state_ff, state_in;
   logic [NW-1:0] num_ff, num_in, val_ff, val_in, rot_ff, rot_in;
   logic [cpt_pkg::DivW-1:0] d_ff, d_in;
   logic [DW-1:0] len_ff, len_in, left_ff, left_in;
   logic bad_ff, bad_in, res_ff, res_in, rv_ff, rv_in;
   logic [NW-1:0] top;
   logic [2*cpt_pkg::DivW-1:0] dsq;
   logic [NW+3:0] tenmax;
   logic [NW+3:0] rotv;
   logic [3:0] dig;
   logic prime_done, prime_res;

   assign top = NW'(cpt_pkg::pow_ten(DW'(len_ff - 1'b1)));
   assign tenmax = cpt_pkg::pow_ten(DW'(cpt_pkg::MaxDigits));
   assign dsq = d_ff * d_ff;
   assign dig = drsp.rem[3:0];
   assign rotv = (NW+4)'(drsp.rem) * (NW+4)'(10) + (NW+4)'(drsp.quot);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cpt_pkg::ST_IDLE:
            if (req_valid && !rv_ff) state_in = cpt_pkg::ST_SCAN;
         cpt_pkg::ST_SCAN: state_in = cpt_pkg::ST_SCAN_WAIT;
         cpt_pkg::ST_SCAN_WAIT:
            if (drsp.done) begin
               if (drsp.quot == '0) state_in = cpt_pkg::ST_TEST;
               else state_in = cpt_pkg::ST_SCAN;
            end
         cpt_pkg::ST_TEST: state_in = prime_done ? cpt_pkg::ST_ROT : cpt_pkg::ST_DIV_WAIT;
         cpt_pkg::ST_DIV_WAIT:
            if (drsp.done) state_in = cpt_pkg::ST_NEXT_DIV;
         cpt_pkg::ST_NEXT_DIV: state_in = cpt_pkg::ST_TEST;
         cpt_pkg::ST_ROT: state_in = cpt_pkg::ST_ROT_WAIT;
         cpt_pkg::ST_ROT_WAIT:
            if (drsp.done) state_in = cpt_pkg::ST_TEST;
         cpt_pkg::ST_DONE:
            state_in = cpt_pkg::ST_IDLE;
         default: state_in = cpt_pkg::ST_IDLE;
      endcase
      // early exits
      if (state_ff == cpt_pkg::ST_IDLE && req_valid && !rv_ff &&
          ({4'd0, req_number} >= tenmax || req_number < NW'(2)))
         state_in = cpt_pkg::ST_DONE;
      if (state_ff == cpt_pkg::ST_SCAN_WAIT && drsp.done && drsp.quot == '0 &&
          len_ff != '0 && bad_in)
         state_in = cpt_pkg::ST_DONE;
      if (state_ff == cpt_pkg::ST_TEST && prime_done &&
          (!prime_res || left_ff == DW'(1)))
         state_in = cpt_pkg::ST_DONE;
   end

   // primality of rot_ff given divisor d_ff
   always_comb begin
      prime_done = 1'b0;
      prime_res = 1'b1;
      if (rot_ff == NW'(2)) prime_done = 1'b1;
      else if (rot_ff < NW'(2) || !rot_ff[0]) begin
         prime_done = 1'b1;
         prime_res = 1'b0;
      end else if ({2'b0, dsq} > 34'(rot_ff)) prime_done = 1'b1;
   end

   // datapath and outputs
   always_comb begin
      num_in = num_ff; val_in = val_ff; rot_in = rot_ff; d_in = d_ff;
      len_in = len_ff; left_in = left_ff; bad_in = bad_ff; res_in = res_ff;
      rv_in = rv_ff;
      dreq.start = 1'b0;
      dreq.dividend = val_ff;
      dreq.divisor = NW'(10);
      if (rsp_valid && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         cpt_pkg::ST_IDLE:
            if (req_valid && !rv_ff) begin
               num_in = req_number; val_in = req_number; rot_in = req_number;
               len_in = '0; bad_in = 1'b0; res_in = 1'b0;
               d_in = cpt_pkg::DivW'(3);
            end
         cpt_pkg::ST_SCAN: dreq.start = 1'b1;
         cpt_pkg::ST_SCAN_WAIT:
            if (drsp.done) begin
               len_in = len_ff + 1'b1;
               val_in = drsp.quot;
               if (!dig[0] || dig == 4'd5) bad_in = 1'b1;
               if (drsp.quot == '0) begin
                  left_in = len_in;
                  if (len_ff == '0) bad_in = 1'b0;
               end
            end
         cpt_pkg::ST_TEST:
            if (prime_done) begin
               res_in = prime_res;
            end else begin
               dreq.start = 1'b1;
               dreq.dividend = rot_ff;
               dreq.divisor = NW'(d_ff);
            end
         cpt_pkg::ST_DIV_WAIT:
            if (drsp.done && drsp.rem == '0) begin
               res_in = 1'b0;
               rot_in = '0;
            end
         cpt_pkg::ST_NEXT_DIV: d_in = d_ff + cpt_pkg::DivW'(2);
         cpt_pkg::ST_ROT: begin
            dreq.start = 1'b1;
            dreq.dividend = rot_ff;
            dreq.divisor = top;
            left_in = left_ff - 1'b1;
         end
         cpt_pkg::ST_ROT_WAIT:
            if (drsp.done) begin
               rot_in = NW'(rotv);
               d_in = cpt_pkg::DivW'(3);
            end
         cpt_pkg::ST_DONE: rv_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpt_pkg::ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      num_ff <= num_in; val_ff <= val_in; rot_ff <= rot_in; d_ff <= d_in;
      len_ff <= len_in; left_ff <= left_in; bad_ff <= bad_in; res_ff <= res_in;
   end

   assign req_ready = (state_ff == cpt_pkg::ST_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_is_circular_prime = res_ff && (num_ff != '0);
endmodule
`default_nettype wire

FILE: hw/rtl/circular_prime_test_unit.sv
`default_nettype none
// channel | ports                              | role
// req     | req_valid/req_ready/req_number     | candidate in
// rsp     | rsp_valid/rsp_ready/rsp_is_circular_prime | verdict out
// One candidate at a time; every division runs on one shared restoring
// divider, one division per digit for the scan, per trial divisor and per
// rotation (worst case, nine rotations of about 15800 odd divisors each).
// Synchronous active-high reset clears the sequencer. A stalled verdict
// holds in its register; no new transfer is taken until it leaves.
module circular_prime_test_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [cpt_pkg::NumW-1:0] req_number,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_is_circular_prime
);
   cpt_pkg::div_req_type dreq;
   cpt_pkg::div_rsp_type drsp;

   // shared divider for digit scan, trial division and rotation
   cpt_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   cpt_sequencer u_seq (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_number(req_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_is_circular_prime(rsp_is_circular_prime),
      .dreq(dreq), .drsp(drsp)
   );
endmodule
`default_nettype wire

FILE: hw/rtl/cpt_checker.sv
`default_nettype none
module cpt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_is_circular_prime
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while verdict pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_circular_prime))
      else $error("verdict dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after transfer");
endmodule

bind circular_prime_test_unit cpt_checker u_chk (.*);
`default_nettype wire

FILE: dv/tb_circular_prime_test_unit.sv
module tb_circular_prime_test_unit;
   // Cap on the run in clock cycles. The dearest item here is a six-digit
   // circular prime, so this is loose.
   localparam int CycleLimit = 6000000;
   localparam int DrainCycles = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [cpt_pkg::NumW-1:0] req_number = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_is_circular_prime;

   circular_prime_test_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_circular_prime(rsp_is_circular_prime)
   );

   always #6 clock = ~clock;

   logic [cpt_pkg::NumW-1:0] pending_numbers[$];  // candidates waiting to be driven
   bit verdicts_due[$];                  // verdicts owed, oldest first
   int issued = 0;                       // candidates placed on the bus
   int accepted = 0;                     // candidates taken by the block
   int verdicts_seen = 0;
   int mismatches = 0;
   int quiet_idx = 0;                    // hold the bus until the block drains here
   bit stimulus_done = 1'b0;
   longint cycles = 0;

   // Trial division: 2 first, then odd divisors up to the square root.
   function automatic bit trial_prime(longint unsigned x);
      longint unsigned d;
      if (x == 2) return 1'b1;
      if (x < 2 || x % 2 == 0) return 1'b0;
      for (d = 3; d * d <= x; d += 2)
         if (x % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit circular_verdict(logic [cpt_pkg::NumW-1:0] number);
      longint unsigned n, v, top, rot;
      int len;
      n = number;
      if (n >= 64'd1000000000) return 1'b0;
      len = 0;
      v = n;
      while (v != 0) begin
         len++;
         v /= 10;
      end
      if (len <= 1) return trial_prime(n);
      // drop at once on any even digit or a five
      v = n;
      while (v != 0) begin
         if ((v % 10) % 2 == 0 || v % 10 == 5) return 1'b0;
         v /= 10;
      end
      top = 1;
      for (int i = 1; i < len; i++) top *= 10;
      rot = n;
      for (int i = 0; i < len; i++) begin
         if (!trial_prime(rot)) return 1'b0;
         rot = (rot % top) * 10 + rot / top;
      end
      return 1'b1;
   endfunction

   // Number of the given length made only of the digits 1, 3, 7 and 9.
   function automatic logic [cpt_pkg::NumW-1:0] odd_digit_number(int len);
      int unsigned odd_digits[4] = '{1, 3, 7, 9};
      longint unsigned v;
      v = 0;
      for (int i = 0; i < len; i++) v = v * 10 + odd_digits[$urandom_range(3)];
      return cpt_pkg::NumW'(v);
   endfunction

   function automatic bit idle_now(int idx);
      // no idling at all across a stretch in the middle of the run
      if (idx >= 45 && idx < 75) return 1'b0;
      return $urandom_range(99) < 7;
   endfunction

   // Driver: advance to the next candidate once the current one transfers.
   always @(posedge clock) begin
      bit free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         free = !req_valid || req_ready;
         if (req_valid && req_ready) begin
            verdicts_due.push_back(circular_verdict(req_number));
            accepted++;
         end
         if (free) begin
            if (pending_numbers.size() != 0 && !idle_now(issued) &&
                !(issued == quiet_idx && (accepted != issued ||
                  verdicts_due.size() != 0 || (req_valid && req_ready)))) begin
               req_valid <= 1'b1;
               req_number <= pending_numbers.pop_front();
               issued++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check each verdict against the oldest one owed.
   always @(posedge clock) begin
      bit want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected verdict %0b with none owed",
                           rsp_is_circular_prime);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_is_circular_prime !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("verdict %0d: expected %0b, got %0b",
                              verdicts_seen, want, rsp_is_circular_prime);
               end
            end
         end
         if (verdicts_seen >= 45 && verdicts_seen < 75) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(99) >= 7);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int pick;
      // directed: edges of the field, tiny values, good and bad multi-digit
      // candidates, too many digits, and a six-digit circular prime
      pending_numbers = '{0, 1, 2, 3, 4, 5, 7, 9, 11, 13, 19, 23, 37, 71, 111,
                          197, 199, 337, 1193, 999331, 111111111, 999999999,
                          1000000000, 30'h3FFFFFFF, 30'h2AAAAAAA};
      quiet_idx = 60;
      for (int i = 0; i < 75; i++) begin
         pick = $urandom_range(99);
         if (pick < 30)
            pending_numbers.push_back(cpt_pkg::NumW'($urandom_range(999)));
         else if (pick < 60)
            pending_numbers.push_back(odd_digit_number($urandom_range(2, 4)));
         else if (pick < 70) pending_numbers.push_back(odd_digit_number(5));
         else if (pick < 75)
            pending_numbers.push_back(cpt_pkg::NumW'($urandom_range(99999)));
         else if (pick < 95) pending_numbers.push_back(cpt_pkg::NumW'($urandom));
         else
            // nine equal digits, a multiple of three: fives fail the scan, the rest their first divisor
            pending_numbers.push_back(
               cpt_pkg::NumW'(64'd111111111 * (2 * $urandom_range(4) + 1)));
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (pending_numbers.size() == 0 && accepted == issued && !req_valid);
      wait (verdicts_due.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

FILE: sim.f
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_divider.sv
hw/rtl/cpt_sequencer.sv
hw/rtl/circular_prime_test_unit.sv
hw/rtl/cpt_checker.sv
dv/tb_circular_prime_test_unit.sv
